// File: design/dmpts_pkg.sv
package dmpts_pkg;

    localparam int MAX_SUBSTEPS_DEF = 64;
    localparam int QW      = 32;        // Q16.16 word
    localparam int ACC_W   = 35;        // sum of four products
    localparam int GAIN_W  = 24;        // gains, tau, divisor
    localparam int DNUM_W  = 50;        // divider numerator bits
    localparam int DCNT_W  = 6;

    localparam logic MODE_FIT = 1'b0;
    localparam logic MODE_RUN = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [16:0]        phase;
        logic signed [31:0] prediction;
        logic signed [31:0] target_pos;
        logic signed [31:0] target_vel;
        logic signed [31:0] target_acc;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic signed [31:0] forcing;
        logic signed [31:0] fit_sample;
        logic               fit_valid;
        logic               fault;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_STIFFNESS  = 3'd0,
        CFG_DAMPING    = 3'd1,
        CFG_TIME_SCALE = 3'd2,
        CFG_STEP_LEN   = 3'd3,
        CFG_GOAL       = 3'd4,
        CFG_START      = 3'd5,
        CFG_SUBSTEPS   = 3'd6
    } t_cfg_idx;

    typedef enum logic [5:0] {
        U_NOP, U_GS, U_GSX, U_T1A, U_T1B, U_T2A, U_T2B, U_FTN,
        U_DIV_FT, U_WAIT, U_FT1, U_FT2, U_FT3, U_SMPZ, U_DIV_SMP,
        U_DIV_DT, U_FRUN,
        U_E1, U_E2, U_E3, U_E4, U_E5, U_E6, U_E7, U_E8,
        U_DIV_IACC, U_DIV_OVEL, U_DIV_OACC,
        U_E12, U_E13, U_E14, U_E15, U_PUSH
    } t_uop;

    typedef enum logic [5:0] {
        S_IDLE, S_GS, S_GSX, S_T1A, S_T1B, S_T2A, S_T2B, S_FTN,
        S_DFT, S_DFT_W, S_FT1, S_FT2, S_FT3, S_SMPZ, S_DSMP, S_DSMP_W,
        S_DDT, S_DDT_W, S_FRUN,
        S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8,
        S_DIACC, S_DIACC_W, S_DOVEL, S_DOVEL_W, S_DOACC, S_DOACC_W,
        S_E12, S_E13, S_E14, S_E15, S_DONE
    } t_state;

    typedef struct packed {
        t_uop uop;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic x_zero;
        logic mode_run;
        logic cnt_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/dmpts_in_if.sv
interface dmpts_in_if;
    import dmpts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/dmpts_out_if.sv
interface dmpts_out_if;
    import dmpts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/dmpts_div.sv
module dmpts_div
    import dmpts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ACC_W-1:0]  i_dividend,
    input  logic [GAIN_W-1:0]        i_divisor,
    input  logic                     i_raw,
    output logic                     o_done,
    output logic signed [QW-1:0]     o_quot
);
    logic              r_busy, r_done, r_neg, r_zero;
    logic [DCNT_W-1:0] r_cnt;
    logic [DNUM_W-1:0] r_num;
    logic [GAIN_W-1:0] r_rem, r_div;
    logic [ACC_W-1:0]  mag;
    logic [GAIN_W:0]   trial;
    logic              ge;

    assign mag   = i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
    assign trial = {r_rem, r_num[DNUM_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DCNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DNUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_raw ? DNUM_W'(mag) : {mag[DNUM_W-17:0], 16'd0};
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[ACC_W-1];
            r_zero <= (i_dividend == '0);
        end else if (r_busy) begin
            r_rem <= ge ? GAIN_W'(trial - {1'b0, r_div}) : trial[GAIN_W-1:0];
            r_num <= {r_num[DNUM_W-2:0], ge};
        end
    end

    // truncating quotient magnitude, then sign and saturate
    always_comb begin
        if (r_zero)
            o_quot = '0;
        else if (r_neg)
            o_quot = (r_num > DNUM_W'(64'h8000_0000)) ? 32'sh8000_0000
                                                        : QW'(-r_num);
        else
            o_quot = (r_num > DNUM_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                        : QW'(r_num);
    end
    assign o_done = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy) else $error("stray divider done");
endmodule

// File: design/dmpts_ctrl.sv
module dmpts_ctrl
    import dmpts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.uop  = U_NOP;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GS;
                end
            end
            S_GS:   begin o_cmd.uop = U_GS;  n_state = S_GSX; end
            S_GSX:  begin
                o_cmd.uop = U_GSX;
                n_state   = i_stat.mode_run ? S_DDT : S_T1A;
            end
            S_T1A:  begin o_cmd.uop = U_T1A; n_state = S_T1B; end
            S_T1B:  begin o_cmd.uop = U_T1B; n_state = S_T2A; end
            S_T2A:  begin o_cmd.uop = U_T2A; n_state = S_T2B; end
            S_T2B:  begin o_cmd.uop = U_T2B; n_state = S_FTN; end
            S_FTN:  begin o_cmd.uop = U_FTN; n_state = S_DFT; end
            S_DFT:  begin o_cmd.uop = U_DIV_FT; n_state = S_DFT_W; end
            S_DFT_W: begin
                o_cmd.uop = U_WAIT;
                if (i_stat.div_done) n_state = S_FT1;
            end
            S_FT1:  begin o_cmd.uop = U_FT1; n_state = S_FT2; end
            S_FT2:  begin o_cmd.uop = U_FT2; n_state = S_FT3; end
            S_FT3:  begin
                o_cmd.uop = U_FT3;
                n_state   = i_stat.x_zero ? S_SMPZ : S_DSMP;
            end
            S_SMPZ: begin o_cmd.uop = U_SMPZ; n_state = S_E1; end
            S_DSMP: begin o_cmd.uop = U_DIV_SMP; n_state = S_DSMP_W; end
            S_DSMP_W: begin
                o_cmd.uop = U_WAIT;
                if (i_stat.div_done) n_state = S_E1;
            end
            S_DDT:  begin o_cmd.uop = U_DIV_DT; n_state = S_DDT_W; end
            S_DDT_W: begin
                o_cmd.uop = U_WAIT;
                if (i_stat.div_done) n_state = S_FRUN;
            end
            S_FRUN: begin o_cmd.uop = U_FRUN; n_state = S_E1; end
            S_E1:   begin o_cmd.uop = U_E1; n_state = S_E2; end
            S_E2:   begin o_cmd.uop = U_E2; n_state = S_E3; end
            S_E3:   begin o_cmd.uop = U_E3; n_state = S_E4; end
            S_E4:   begin o_cmd.uop = U_E4; n_state = S_E5; end
            S_E5:   begin o_cmd.uop = U_E5; n_state = S_E6; end
            S_E6:   begin o_cmd.uop = U_E6; n_state = S_E7; end
            S_E7:   begin o_cmd.uop = U_E7; n_state = S_E8; end
            S_E8:   begin o_cmd.uop = U_E8; n_state = S_DIACC; end
            S_DIACC: begin o_cmd.uop = U_DIV_IACC; n_state = S_DIACC_W; end
            S_DIACC_W: begin
                o_cmd.uop = U_WAIT;
                if (i_stat.div_done) n_state = S_DOVEL;
            end
            S_DOVEL: begin o_cmd.uop = U_DIV_OVEL; n_state = S_DOVEL_W; end
            S_DOVEL_W: begin
                o_cmd.uop = U_WAIT;
                if (i_stat.div_done) n_state = S_DOACC;
            end
            S_DOACC: begin o_cmd.uop = U_DIV_OACC; n_state = S_DOACC_W; end
            S_DOACC_W: begin
                o_cmd.uop = U_WAIT;
                if (i_stat.div_done) n_state = S_E12;
            end
            S_E12:  begin o_cmd.uop = U_E12; n_state = S_E13; end
            S_E13:  begin o_cmd.uop = U_E13; n_state = S_E14; end
            S_E14:  begin o_cmd.uop = U_E14; n_state = S_E15; end
            S_E15:  begin
                o_cmd.uop = U_E15;
                n_state   = i_stat.cnt_last ? S_DONE : S_E1;
            end
            S_DONE: begin
                o_cmd.uop = U_PUSH;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: design/dmpts_dp.sv
module dmpts_dp
    import dmpts_pkg::*;
#(
    parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);
    localparam int CW = $clog2(MAX_SUBSTEPS + 1);
    localparam logic [8:0] MAX9 = 9'(MAX_SUBSTEPS);

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat41(input logic signed [40:0] v);
        if (!((&v[40:31]) || !(|v[40:31])))
            return v[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    // configuration
    logic [GAIN_W-1:0]  r_k, r_d, r_tau;
    logic [15:0]        r_step;
    logic signed [31:0] r_goal, r_start;
    logic [6:0]         r_sub;
    // item
    logic               r_mode;
    logic [16:0]        r_x;
    logic signed [31:0] r_pred, r_tp, r_tv, r_ta;
    // integrator state
    logic signed [31:0] r_pos, r_ivel, r_iacc, r_ovel, r_oacc, r_ft;
    // scratch
    logic signed [31:0] r_gs, r_gsx, r_t, r_m, r_sample;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_fvalid, r_fault;
    logic [15:0]        r_dt;
    logic [CW-1:0]      r_cnt;
    t_uop               r_dst;
    logic               r_ovalid;
    t_out_item          r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 24'd65536; r_d <= 24'd65536; r_tau <= 24'd65536;
            r_step <= 16'd655; r_goal <= '0; r_start <= '0; r_sub <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STIFFNESS:  r_k     <= i_cfg_data[23:0];
                CFG_DAMPING:    r_d     <= i_cfg_data[23:0];
                CFG_TIME_SCALE: r_tau   <= i_cfg_data[23:0];
                CFG_STEP_LEN:   r_step  <= i_cfg_data[15:0];
                CFG_GOAL:       r_goal  <= i_cfg_data;
                CFG_START:      r_start <= i_cfg_data;
                CFG_SUBSTEPS:   r_sub   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // clamped sub-step count
    logic [8:0]    sub9, n9;
    logic [CW-1:0] n_sub;
    assign sub9  = 9'(r_sub);
    assign n9    = (sub9 == 9'd0) ? 9'd1 : ((sub9 > MAX9) ? MAX9 : sub9);
    assign n_sub = CW'(n9);

    // shared multiplier: Q16.16 times unsigned gain, floor, saturate
    logic signed [31:0]     mul_a;
    logic [GAIN_W-1:0]      mul_b;
    logic signed [56:0]     prod;
    logic signed [31:0]     mq;
    always_comb begin
        mul_a = r_t;
        mul_b = r_k;
        case (i_cmd.uop)
            U_GSX:  begin mul_a = r_gs;   mul_b = GAIN_W'(r_x);  end
            U_T1A:  begin mul_a = r_ta;   mul_b = r_tau;         end
            U_T1B:  begin mul_a = r_t;    mul_b = r_tau;         end
            U_T2A:  begin mul_a = r_tv;   mul_b = r_d;           end
            U_T2B:  begin mul_a = r_m;    mul_b = r_tau;         end
            U_FRUN: begin mul_a = r_pred; mul_b = GAIN_W'(r_x);  end
            U_E3:   begin mul_a = r_ivel; mul_b = r_d;           end
            U_E5:   begin mul_a = r_gsx;  mul_b = r_k;           end
            U_E7:   begin mul_a = r_ft;   mul_b = r_k;           end
            U_E12:  begin mul_a = r_iacc; mul_b = GAIN_W'(r_dt); end
            U_E14:  begin mul_a = r_ovel; mul_b = GAIN_W'(r_dt); end
            default: ;
        endcase
    end
    assign prod = 57'(mul_a) * 57'($signed({1'b0, mul_b}));
    assign mq   = sat41(prod[56:16]);

    // shared divider
    logic                    div_start, div_raw, div_done;
    logic signed [ACC_W-1:0] div_num;
    logic [GAIN_W-1:0]       div_den;
    logic signed [31:0]      div_q;
    always_comb begin
        div_start = 1'b1;
        div_raw   = 1'b0;
        div_num   = r_acc;
        div_den   = r_tau;
        case (i_cmd.uop)
            U_DIV_FT:   div_den = r_k;
            U_DIV_SMP:  begin div_num = ACC_W'(r_ft); div_den = GAIN_W'(r_x); end
            U_DIV_DT:   begin
                div_num = $signed(ACC_W'(r_step));
                div_den = GAIN_W'(n_sub);
                div_raw = 1'b1;
            end
            U_DIV_IACC: ;
            U_DIV_OVEL: div_num = ACC_W'(r_ivel);
            U_DIV_OACC: div_num = ACC_W'(r_iacc);
            default:    div_start = 1'b0;
        endcase
    end

    dmpts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .i_raw      (div_raw),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    logic out_free, push;
    assign out_free = !r_ovalid || i_out_ready;
    assign push     = (i_cmd.uop == U_PUSH) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ivel <= '0; r_iacc <= '0;
            r_ovel <= '0; r_oacc <= '0; r_ft <= '0;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (r_ovalid && i_out_ready && !push) r_ovalid <= 1'b0;
            if (div_start) r_dst <= i_cmd.uop;
            if (i_cmd.load) begin
                r_mode <= i_item.mode; r_x <= i_item.phase;
                r_pred <= i_item.prediction; r_tp <= i_item.target_pos;
                r_tv <= i_item.target_vel; r_ta <= i_item.target_acc;
                r_sample <= '0; r_fvalid <= 1'b0; r_fault <= 1'b0;
            end
            case (i_cmd.uop) inside
                U_GS:   r_gs  <= sat33(33'(r_goal) - 33'(r_start));
                U_GSX:  r_gsx <= mq;
                U_T1A, U_T1B: r_t <= mq;
                U_T2A, U_T2B: r_m <= mq;
                U_FTN:  r_acc <= ACC_W'(sat33(33'(r_t) + 33'(r_m)));
                U_FT1:  r_t  <= sat33(33'(r_goal) - 33'(r_tp));
                // ft - (g - target_pos) + gsx is summed exactly, saturated once
                U_FT2:  r_acc <= ACC_W'(r_ft) - ACC_W'(r_t);
                U_FT3:  begin
                    r_ft  <= sat41(41'(r_acc + ACC_W'(r_gsx)));
                    r_dt  <= r_step;
                    r_cnt <= CW'(1);
                end
                U_SMPZ: begin
                    r_fault  <= 1'b1;
                    r_sample <= r_ft[31] ? 32'sh8000_0000 :
                                ((r_ft == '0) ? 32'sh0 : 32'sh7FFF_FFFF);
                end
                U_DIV_DT: r_cnt <= n_sub;
                U_FRUN: r_ft <= mq;
                U_WAIT: if (div_done) begin
                    case (r_dst)
                        U_DIV_FT:   r_ft <= div_q;
                        U_DIV_SMP:  begin r_sample <= div_q; r_fvalid <= 1'b1; end
                        U_DIV_DT:   r_dt <= div_q[15:0];
                        U_DIV_IACC: r_iacc <= div_q;
                        U_DIV_OVEL: r_ovel <= div_q;
                        U_DIV_OACC: r_oacc <= div_q;
                        default: ;
                    endcase
                end
                U_E1:   r_t <= sat33(33'(r_goal) - 33'(r_pos));
                U_E2:   r_acc <= ACC_W'(mq);
                U_E3, U_E5, U_E7, U_E12, U_E14: r_m <= mq;
                U_E4, U_E6: r_acc <= r_acc - ACC_W'(r_m);
                U_E8:   r_acc <= r_acc + ACC_W'(r_m);
                U_E13:  r_ivel <= sat33(33'(r_ivel) + 33'(r_m));
                U_E15:  begin
                    r_pos <= sat33(33'(r_pos) + 33'(r_m));
                    r_cnt <= r_cnt - CW'(1);
                end
                U_PUSH: if (out_free) begin
                    r_ovalid           <= 1'b1;
                    r_out.position     <= r_pos;
                    r_out.velocity     <= r_ovel;
                    r_out.acceleration <= r_oacc;
                    r_out.forcing      <= r_ft;
                    r_out.fit_sample   <= r_sample;
                    r_out.fit_valid    <= r_fvalid;
                    r_out.fault        <= r_fault;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.x_zero   = (r_x == '0);
    assign o_stat.mode_run = (r_mode == MODE_RUN);
    assign o_stat.cnt_last = (r_cnt == CW'(1));
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_ovalid;
    assign o_out_item      = r_out;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_out.fit_valid && r_out.fault))
        else $error("sample both valid and faulted");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.uop == U_E15) |-> (r_cnt != '0))
        else $error("sub-step counter underflow");
endmodule

// File: design/dmp_transformation_step_unit.sv
// Channel   Dir  Payload      Notes
// i_in      in   t_in_item    mode, phase, prediction, targets; taken when idle
// o_res     out  t_out_item   position, velocity, acceleration, forcing, sample
// i_cfg_*   in   index, data  register write, only while no item is in flight
//
// One item at a time. Every Q16.16 division runs on a shared restoring
// divider at one quotient bit a cycle; products use one 32x24 multiplier.
// A fit item with zero phase skips the sample division. A run item
// repeats the Euler sub-step loop once for every sub-step.
// Reset (sync, active low) clears the integrator state and loads default
// gains. A finished result sits in the output register; a stalled output
// holds the controller in its last state.
module dmp_transformation_step_unit
    import dmpts_pkg::*;
#(
    parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    dmpts_in_if.sink    i_in,
    dmpts_out_if.source o_res
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: walks the fit / run flow and the Euler sub-step loop
    dmpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // registers, shared multiplier, divider, output register
    dmpts_dp #(.MAX_SUBSTEPS(MAX_SUBSTEPS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_item  (o_res.data)
    );
endmodule
